// File: hw/rtl/opp_pkg.sv
// ----------------------------------------------------------------------------
// opp_pkg
// shared constants, codes and types of the operator precedence parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package opp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int POS_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DEPTH_W     = 6;
    localparam int TOKEN_W     = 2;
    localparam int ACTION_W    = 3;
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 16;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [PADDR_W-3:0] REG_PREC_TABLE = '0;

    localparam logic [TOKEN_W-1:0] SYM_ID    = 2'd0;
    localparam logic [TOKEN_W-1:0] SYM_PLUS  = 2'd1;
    localparam logic [TOKEN_W-1:0] SYM_TIMES = 2'd2;
    localparam logic [TOKEN_W-1:0] SYM_END   = 2'd3;

    localparam logic [1:0] CODE_LOWER   = 2'd1;
    localparam logic [1:0] CODE_GREATER = 2'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SHIFT     = 3'd0,
        ACT_RED_ID    = 3'd1,
        ACT_RED_PLUS  = 3'd2,
        ACT_RED_TIMES = 3'd3,
        ACT_ACCEPT    = 3'd4,
        ACT_ERROR     = 3'd5,
        ACT_OVERFLOW  = 3'd6
    } action_t;

    // link kept with each pushed terminal: the top terminal below it
    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [TOKEN_W-1:0] sym;
    } stk_entry_t;

    typedef struct packed {
        logic              en;
        logic [POS_W-1:0]  addr;
        stk_entry_t        data;
    } stk_wr_t;

endpackage

// File: hw/rtl/opp_stack_mem.sv
// ----------------------------------------------------------------------------
// opp_stack_mem
// symbol stack memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module opp_stack_mem (
    input  logic                     aclk,
    input  opp_pkg::stk_wr_t         wr,
    input  logic [opp_pkg::POS_W-1:0] raddr,
    output opp_pkg::stk_entry_t      rdata
);
    import opp_pkg::*;

    stk_entry_t mem [STACK_DEPTH];
    stk_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/opp_cfg.sv
// ----------------------------------------------------------------------------
// opp_cfg
// register port holding the precedence table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module opp_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [opp_pkg::PADDR_W-1:0] paddr,
    input  logic [opp_pkg::PDATA_W-1:0] pwdata,
    output logic [opp_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [31:0]                 prec_table
);
    import opp_pkg::*;

    logic [31:0]         prec_table_reg;
    logic [PADDR_W-3:0]  reg_idx;
    logic                wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready && (reg_idx == REG_PREC_TABLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prec_table_reg <= '0;
        end else if (wr_en) begin
            prec_table_reg <= pwdata;
        end
    end

    assign prdata     = (reg_idx == REG_PREC_TABLE) ? prec_table_reg : '0;
    assign prec_table = prec_table_reg;

endmodule

// File: hw/rtl/opp_ctrl.sv
// ----------------------------------------------------------------------------
// opp_ctrl
// parse sequencer: table lookup, shift and reduce, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module opp_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [opp_pkg::TOKEN_W-1:0]  s_token,
    input  logic [31:0]                  prec_table,
    output opp_pkg::stk_wr_t             mem_wr,
    output logic [opp_pkg::POS_W-1:0]    mem_raddr,
    input  opp_pkg::stk_entry_t          mem_rdata,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [opp_pkg::ACTION_W-1:0] m_action,
    output logic [opp_pkg::DEPTH_W-1:0]  m_depth,
    output logic                         m_last
);
    import opp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EVAL  = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [TOKEN_W-1:0]  tok_reg, tok_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [POS_W-1:0]    tt_pos_reg, tt_pos_next;
    logic [TOKEN_W-1:0]  tt_sym_reg, tt_sym_next;
    logic [POS_W-1:0]    k_reg, k_next;
    logic                m_valid_reg, m_valid_next;
    action_t             m_action_reg, m_action_next;
    logic [DEPTH_W-1:0]  m_depth_reg, m_depth_next;
    logic                m_last_reg, m_last_next;

    logic                out_free;
    logic [1:0]          code;
    logic                accept_form;
    logic                id_ok;
    logic                op_ok;

    assign out_free    = !m_valid_reg || m_ready;
    assign code        = prec_table[{tt_sym_reg, tok_reg, 1'b0} +: 2];
    assign accept_form = (tok_reg == SYM_END) && (count_reg == CNT_W'(2)) &&
                         (tt_pos_reg == '0);
    assign id_ok       = (tt_sym_reg == SYM_ID) &&
                         (CNT_W'(tt_pos_reg) + CNT_W'(1) == count_reg);
    assign op_ok       = ((tt_sym_reg == SYM_PLUS) || (tt_sym_reg == SYM_TIMES)) &&
                         (CNT_W'(tt_pos_reg) + CNT_W'(2) == count_reg);

    always_comb begin
        state_next    = state_reg;
        tok_next      = tok_reg;
        count_next    = count_reg;
        tt_pos_next   = tt_pos_reg;
        tt_sym_next   = tt_sym_reg;
        k_next        = k_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_action_next = m_action_reg;
        m_depth_next  = m_depth_reg;
        m_last_next   = m_last_reg;
        mem_wr        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    tok_next   = s_token;
                    k_next     = '0;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (out_free) begin
                    if (accept_form || k_reg == POS_W'(STACK_DEPTH - 1) ||
                        (code == CODE_LOWER && count_reg >= CNT_W'(STACK_DEPTH)) ||
                        !((code == CODE_LOWER) ||
                          (code == CODE_GREATER && (id_ok || op_ok)))) begin
                        // terminal result with restart
                        m_valid_next  = 1'b1;
                        m_depth_next  = DEPTH_W'(1);
                        m_last_next   = 1'b1;
                        if (accept_form) begin
                            m_action_next = ACT_ACCEPT;
                        end else if (k_reg != POS_W'(STACK_DEPTH - 1) &&
                                     code == CODE_LOWER) begin
                            m_action_next = ACT_OVERFLOW;
                        end else begin
                            m_action_next = ACT_ERROR;
                        end
                        count_next  = CNT_W'(1);
                        tt_pos_next = '0;
                        tt_sym_next = SYM_END;
                        state_next  = ST_IDLE;
                    end else if (code == CODE_LOWER) begin
                        mem_wr.en       = 1'b1;
                        mem_wr.addr     = count_reg[POS_W-1:0];
                        mem_wr.data.pos = tt_pos_reg;
                        mem_wr.data.sym = tt_sym_reg;
                        tt_pos_next     = count_reg[POS_W-1:0];
                        tt_sym_next     = tok_reg;
                        count_next      = count_reg + CNT_W'(1);
                        m_valid_next    = 1'b1;
                        m_action_next   = ACT_SHIFT;
                        m_depth_next    = DEPTH_W'(count_reg + CNT_W'(1));
                        m_last_next     = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (tt_sym_reg == SYM_ID) begin
                        m_action_next = ACT_RED_ID;
                        m_depth_next  = DEPTH_W'(count_reg);
                        m_last_next   = 1'b0;
                        tt_pos_next   = mem_rdata.pos;
                        tt_sym_next   = mem_rdata.sym;
                        k_next        = k_reg + POS_W'(1);
                        state_next    = ST_EVAL;
                    end else if (mem_rdata.pos == tt_pos_reg - POS_W'(1)) begin
                        // no E directly below the operator
                        m_action_next = ACT_ERROR;
                        m_depth_next  = DEPTH_W'(1);
                        m_last_next   = 1'b1;
                        count_next    = CNT_W'(1);
                        tt_pos_next   = '0;
                        tt_sym_next   = SYM_END;
                        state_next    = ST_IDLE;
                    end else begin
                        m_action_next = (tt_sym_reg == SYM_PLUS) ? ACT_RED_PLUS
                                                                 : ACT_RED_TIMES;
                        count_next    = count_reg - CNT_W'(2);
                        m_depth_next  = DEPTH_W'(count_reg - CNT_W'(2));
                        m_last_next   = 1'b0;
                        tt_pos_next   = mem_rdata.pos;
                        tt_sym_next   = mem_rdata.sym;
                        k_next        = k_reg + POS_W'(1);
                        state_next    = ST_EVAL;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= CNT_W'(1);
            tt_pos_reg  <= '0;
            tt_sym_reg  <= SYM_END;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            tt_pos_reg  <= tt_pos_next;
            tt_sym_reg  <= tt_sym_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg      <= tok_next;
        m_action_reg <= m_action_next;
        m_depth_reg  <= m_depth_next;
        m_last_reg   <= m_last_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign mem_raddr = tt_pos_reg;
    assign m_valid   = m_valid_reg;
    assign m_action  = m_action_reg;
    assign m_depth   = m_depth_reg;
    assign m_last    = m_last_reg;

endmodule

// File: hw/rtl/operator_precedence_parser_core.sv
// ----------------------------------------------------------------------------
// operator_precedence_parser_core
// shift-reduce parser for E -> id | E+E | E*E with a programmable table
// timing: after a token request is accepted the first result is registered out
// of EVAL, or out of APPLY when the first step is a reduce; output stalls hold both
// throughput: one token at a time, each an EVAL pass plus an EVAL and APPLY pass
// per reduction with one stack memory read, sequenced by the parse state machine
// reset: stack holds the end marker only, precedence table cleared,
// no clearing pass over the stack memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module operator_precedence_parser_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [opp_pkg::S_DATA_W-1:0] s_tdata,   // token[1:0], zero fill
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [opp_pkg::M_DATA_W-1:0] m_tdata,   // action[2:0], depth_after[8:3]
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [opp_pkg::PADDR_W-1:0]  paddr,
    input  logic [opp_pkg::PDATA_W-1:0]  pwdata,
    output logic [opp_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import opp_pkg::*;

    logic [31:0]          prec_table;
    stk_wr_t              mem_wr;
    logic [POS_W-1:0]     mem_raddr;
    stk_entry_t           mem_rdata;
    logic [ACTION_W-1:0]  m_action;
    logic [DEPTH_W-1:0]   m_depth;

    opp_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .prec_table (prec_table)
    );

    opp_stack_mem u_stack (
        .aclk  (aclk),
        .wr    (mem_wr),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    opp_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_token    (s_tdata[TOKEN_W-1:0]),
        .prec_table (prec_table),
        .mem_wr     (mem_wr),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_action   (m_action),
        .m_depth    (m_depth),
        .m_last     (m_tlast)
    );

    assign m_tdata = {{(M_DATA_W - ACTION_W - DEPTH_W){1'b0}}, m_depth, m_action};

`ifndef SYNTH
    // final result of a token is exactly shift, accept, error or overflow
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == ((m_action == ACT_SHIFT) || (m_action == ACT_ACCEPT) ||
                                  (m_action == ACT_ERROR) || (m_action == ACT_OVERFLOW))))
        else $error("tlast does not match action kind");

    // restart leaves only the bottom marker
    a_restart_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ((m_action == ACT_ACCEPT) || (m_action == ACT_ERROR) ||
                      (m_action == ACT_OVERFLOW))) |-> (m_depth == DEPTH_W'(1)))
        else $error("restart result with depth other than one");

    // one token at a time
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("token request taken while parse in progress");

    // no stack write when the stack is full
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr.en |-> (mem_wr.addr != '0))
        else $error("stack write over bottom marker");
`endif

endmodule

// File: tb/sv/operator_precedence_parser_core_tb.sv
// ----------------------------------------------------------------------------
// operator_precedence_parser_core_tb
// self-checking bench for the shift-reduce expression parser: token requests
// go in through a bursty stream source, every result is compared field by
// field against a bit-true parser model kept in the bench, the precedence
// table is reprogrammed over the register port between test phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module operator_precedence_parser_core_tb;

    import opp_pkg::*;

    localparam logic [2:0]  SYM_EXPR       = 3'd4;
    localparam logic [31:0] TBL_STANDARD   = 32'h15A9_99A8;
    localparam logic [31:0] TBL_RIGHT      = 32'h1599_95A8;
    localparam logic [31:0] TBL_ALL_SHIFT  = 32'h5555_5555;
    localparam logic [31:0] TBL_ALL_ERROR  = 32'hFFFF_FFFF;
    localparam logic [31:0] TBL_ID_ID_SHIFT = 32'h15A9_99A9;

    typedef struct {
        action_t              act;
        logic [DEPTH_W-1:0]   depth;
        logic                 last;
    } parse_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // parser model state
    logic [31:0]           prec_table;
    logic [2:0]            pred_stack [STACK_DEPTH];
    int                    pred_depth;
    parse_result_t         expected_results [$];

    int                    error_count = 0;
    bit                    gaps_on = 1'b0;
    int                    burst_left = 0;
    logic [15:0]           ready_phase = '0;
    logic [1:0]            ready_mode = '0;
    logic [15:0]           ready_pattern = 16'hFFFF;
    parse_result_t         got_expected;

    operator_precedence_parser_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------
    function automatic void clear_stack();
        foreach (pred_stack[i]) pred_stack[i] = '0;
        pred_stack[0] = {1'b0, SYM_END};
        pred_depth = 1;
    endfunction

    function automatic void push_result(action_t a, int depth, logic last);
        parse_result_t r;
        r.act   = a;
        r.depth = DEPTH_W'(depth);
        r.last  = last;
        expected_results = {expected_results, r};
    endfunction

    function automatic void parse_token(logic [TOKEN_W-1:0] tok);
        int         reductions;
        int         p;
        int         idx;
        logic [1:0] top;
        logic [1:0] code;
        bit         done;
        reductions = 0;
        done = 1'b0;
        while (!done) begin
            if (tok == SYM_END && pred_depth == 2 && pred_stack[0] == {1'b0, SYM_END} &&
                pred_stack[1] == SYM_EXPR) begin
                clear_stack();
                push_result(ACT_ACCEPT, pred_depth, 1'b1);
                done = 1'b1;
            end else if (reductions >= STACK_DEPTH - 1) begin
                clear_stack();
                push_result(ACT_ERROR, pred_depth, 1'b1);
                done = 1'b1;
            end else begin
                p = pred_depth - 1;
                while (p > 0 && pred_stack[p] == SYM_EXPR) p--;
                top  = pred_stack[p][1:0];
                idx  = 2 * (int'(top) * 4 + int'(tok));
                code = prec_table[idx +: 2];
                if (code == CODE_LOWER) begin
                    if (pred_depth >= STACK_DEPTH) begin
                        clear_stack();
                        push_result(ACT_OVERFLOW, pred_depth, 1'b1);
                    end else begin
                        pred_stack[pred_depth] = {1'b0, tok};
                        pred_depth++;
                        push_result(ACT_SHIFT, pred_depth, 1'b1);
                    end
                    done = 1'b1;
                end else if (code == CODE_GREATER && top == SYM_ID &&
                             p + 1 == pred_depth) begin
                    pred_stack[p] = SYM_EXPR;
                    push_result(ACT_RED_ID, pred_depth, 1'b0);
                    reductions++;
                end else if (code == CODE_GREATER && (top == SYM_PLUS || top == SYM_TIMES) &&
                             p >= 1 && p + 2 == pred_depth &&
                             pred_stack[p-1] == SYM_EXPR && pred_stack[p+1] == SYM_EXPR) begin
                    pred_depth -= 2;
                    pred_stack[p-1] = SYM_EXPR;
                    push_result(top == SYM_PLUS ? ACT_RED_PLUS : ACT_RED_TIMES,
                                pred_depth, 1'b0);
                    reductions++;
                end else begin
                    clear_stack();
                    push_result(ACT_ERROR, pred_depth, 1'b1);
                    done = 1'b1;
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d %0d %0b",
                         $time, m_tdata[2:0], m_tdata[3 +: DEPTH_W], m_tlast);
                error_count++;
            end else begin
                got_expected = expected_results.pop_front();
                if (m_tdata[2:0] !== got_expected.act) begin
                    $display("%0t: action mismatch, expected %0d actual %0d",
                             $time, got_expected.act, m_tdata[2:0]);
                    error_count++;
                end
                if (m_tdata[3 +: DEPTH_W] !== got_expected.depth) begin
                    $display("%0t: depth_after mismatch, expected %0d actual %0d",
                             $time, got_expected.depth, m_tdata[3 +: DEPTH_W]);
                    error_count++;
                end
                if (m_tlast !== got_expected.last) begin
                    $display("%0t: last mismatch, expected %0b actual %0b",
                             $time, got_expected.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        ready_phase <= ready_phase + 16'd1;
        if (ready_phase[5:0] == 6'd0) begin
            ready_mode    <= 2'($urandom_range(0, 2));
            ready_pattern <= 16'($urandom) | 16'h0001;
        end
        case (ready_mode)
            2'd0: begin
                m_tready <= 1'b1;
            end
            2'd1: begin
                m_tready <= ready_pattern[ready_phase[3:0]];
            end
            default: begin
                m_tready <= ($urandom_range(0, 2) != 0);
            end
        endcase
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_token(input logic [TOKEN_W-1:0] tok);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(tok);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        parse_token(tok);
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_prec_table(input logic [31:0] value);
        wait_results_done();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PREC_TABLE, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        prec_table = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_expression(input int n_ids, input bit broken);
        logic [TOKEN_W-1:0] toks [$];
        int                 k;
        for (int i = 0; i < n_ids; i++) begin
            if (i > 0) toks = {toks, ($urandom_range(0, 1) ? SYM_PLUS : SYM_TIMES)};
            toks = {toks, SYM_ID};
        end
        toks = {toks, SYM_END};
        if (broken) begin
            k = $urandom_range(0, toks.size() - 1);
            if ($urandom_range(0, 1)) toks.delete(k);
            else toks[k] = TOKEN_W'($urandom_range(0, 3));
        end
        foreach (toks[j]) send_token(toks[j]);
    endtask

    task automatic send_plus_chain(input int n_ids);
        for (int i = 0; i < n_ids; i++) begin
            if (i > 0) send_token(SYM_PLUS);
            send_token(SYM_ID);
        end
        send_token(SYM_END);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_table_extremes();
        gaps_on = 1'b0;
        send_token(SYM_ID);
        write_prec_table(32'h0000_0000);
        send_token(SYM_END);
        write_prec_table(TBL_ALL_ERROR);
        send_token(SYM_PLUS);
        send_token(SYM_TIMES);
        // end marker gets shifted like any terminal
        write_prec_table(TBL_ALL_SHIFT);
        send_token(SYM_END);
        send_token(SYM_END);
        send_token(SYM_ID);
    endtask

    task automatic test_directed_cases();
        write_prec_table(TBL_STANDARD);
        gaps_on = 1'b1;
        send_token(SYM_ID);
        send_token(SYM_END);
        // end marker on an empty stack
        send_token(SYM_END);
        send_token(SYM_ID);
        send_token(SYM_ID);
        send_token(SYM_ID);
        send_token(SYM_PLUS);
        send_token(SYM_ID);
        send_token(SYM_TIMES);
        send_token(SYM_ID);
        send_token(SYM_END);
        // operator without a left operand
        send_token(SYM_PLUS);
        send_token(SYM_ID);
        send_token(SYM_END);
        // operator without a right operand
        send_token(SYM_ID);
        send_token(SYM_PLUS);
        send_token(SYM_END);
        // id with an expression above it
        write_prec_table(TBL_ID_ID_SHIFT);
        send_token(SYM_ID);
        send_token(SYM_ID);
        send_token(SYM_PLUS);
    endtask

    task automatic test_random_expressions();
        write_prec_table(TBL_STANDARD);
        for (int e = 0; e < 5; e++) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if (e == 4) wait_results_done();
            if ($urandom_range(0, 7) == 0) send_token(TOKEN_W'($urandom_range(0, 3)));
            send_expression($urandom_range(1, 8), $urandom_range(0, 5) == 0);
        end
    endtask

    task automatic test_deep_reductions();
        write_prec_table(TBL_RIGHT);
        gaps_on = 1'b0;
        send_plus_chain($urandom_range(4, 10));
        gaps_on = 1'b1;
        send_plus_chain($urandom_range(4, 10));
        send_plus_chain(16);
        // one more operand than the stack can take
        send_plus_chain(17);
    endtask

    task automatic test_stack_overflow();
        write_prec_table(TBL_ALL_SHIFT);
        gaps_on = 1'b1;
        repeat (STACK_DEPTH + 2) send_token(TOKEN_W'($urandom_range(0, 3)));
    endtask

    task automatic test_random_tables();
        logic [31:0] tbl;
        for (int t = 0; t < 3; t++) begin
            if (t == 0) begin
                tbl = $urandom;
            end else begin
                tbl = TBL_STANDARD;
                repeat (3) tbl[2 * $urandom_range(0, 15) +: 2] = 2'($urandom_range(0, 3));
            end
            write_prec_table(tbl);
            gaps_on = 1'($urandom_range(0, 1));
            repeat (5) send_token(TOKEN_W'($urandom_range(0, 3)));
        end
    endtask

    initial begin
        prec_table = '0;
        clear_stack();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_table_extremes();
        test_directed_cases();
        test_random_expressions();
        test_deep_reductions();
        test_stack_overflow();
        test_random_tables();
        wait_results_done();
        repeat (20) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("operator_precedence_parser_core_tb: clean");
        end else begin
            $display("operator_precedence_parser_core_tb: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("operator_precedence_parser_core_tb: errors");
        $finish;
    end

endmodule
